>>> hdl/cqs_pkg.sv
package cqs_pkg;

   // Build defaults
   localparam int CQS_DEPTH      = 64;
   localparam int CQS_DATA_WIDTH = 32;

   // Register file
   localparam int          CAP_W      = 7;
   localparam int          CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_ENQUEUE  = 2'd0,
      CMD_DEQUEUE  = 2'd1,
      CMD_TRAVERSE = 2'd2,
      CMD_SEARCH   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_POST = 5'b00010,
      S_DEQ  = 5'b00100,
      S_TRAV = 5'b01000,
      S_SCAN = 5'b10000
   } state_type;

   // Register block to queue control
   typedef struct packed {
      logic [CAP_W-1:0] cap;        // clamped capacity, 1..DEPTH
      logic             idx_clear;  // accepted capacity write: rewind pointers
   } csr_ctl_type;

endpackage

>>> hdl/circular_queue_with_search_top.sv
// Channel  | Dir | Beat contents
// ---------+-----+------------------------------------------------------------
// req_*    | in  | tuser: command; tdata: value
// rsp_*    | out | tdata: status, data, match_count; tlast: last
// csr_*    | in  | APB register port, capacity at byte address 0
//
// Enqueue and every error reply pass through S_POST, dequeue through S_DEQ,
// before the result register. Traverse sends one beat per stored word, search
// compares every stored slot, then replies: one shared read port walks the slots.
// Back-pressure on rsp stalls the traverse walk and the final reply;
// req_tready is low until the command ends.
// Synchronous reset empties the queue and sets capacity to 64; no clearing pass.
module circular_queue_with_search_top #(
   parameter int DEPTH      = cqs_pkg::CQS_DEPTH,
   parameter int DATA_WIDTH = cqs_pkg::CQS_DATA_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // [31:0] value
   input  logic [1:0]                     req_tuser,   // [1:0] command
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [47:0]                    rsp_tdata,   // [1:0] status, [33:2] data,
                                                       // [40:34] match_count
   output logic                           rsp_tlast,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cqs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import cqs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   csr_ctl_type            csr_ctl;
   logic [OCC_W-1:0]       cap;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       tail_ff, tail_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic [IDX_W-1:0]       walk_ff, walk_in;
   logic [OCC_W-1:0]       remain_ff, remain_in;
   logic [OCC_W-1:0]       count_ff, count_in;
   logic [DATA_WIDTH-1:0]  key_ff, key_in;
   status_type             post_ff, post_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_data_ff, rsp_data_in;
   logic [CAP_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [IDX_W-1:0]       ram_rd_addr;
   logic [DATA_WIDTH-1:0]  ram_wr_data, ram_rd_data;

   logic                   req_fire, out_free, hit;
   command_type            cmd;
   logic [63:0]            val_ext, rd_ext;
   logic [DATA_WIDTH-1:0]  val_word;
   logic [31:0]            rd_word32;
   logic [IDX_W-1:0]       tail_dn, walk_dn, head_up, walk_up;

   // Ring pointer steps within the live capacity
   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [OCC_W-1:0] c);
      logic [OCC_W-1:0] nxt;
      nxt = OCC_W'(idx) + OCC_W'(1);
      return (nxt >= c) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [OCC_W-1:0] c);
      logic [OCC_W-1:0] cm1;
      cm1 = c - OCC_W'(1);
      return (idx == '0 || OCC_W'(idx) >= c) ? cm1[IDX_W-1:0] : idx - IDX_W'(1);
   endfunction

   cqs_csr #(
      .DEPTH (DEPTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .queue_empty (occ_ff == '0),
      .ctl         (csr_ctl)
   );

   cqs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign cap = csr_ctl.cap[OCC_W-1:0];

   // Word width adaptation: stored words keep the low DATA_WIDTH bits
   assign val_ext     = 64'(req_tdata);
   assign val_word    = val_ext[DATA_WIDTH-1:0];
   assign ram_wr_data = val_word;
   assign rd_ext      = 64'(ram_rd_data);
   assign rd_word32   = rd_ext[31:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cmd        = command_type'(req_tuser);
   assign hit        = (ram_rd_data == key_ff);

   assign tail_dn = step_down(tail_ff, cap);
   assign walk_dn = step_down(walk_ff, cap);
   assign head_up = step_up(head_ff, cap);
   assign walk_up = step_up(walk_ff, cap);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      walk_in       = walk_ff;
      remain_in     = remain_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      post_in       = post_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = walk_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               count_in = '0;
               state_in = S_POST;
               if (occ_ff == '0 && cmd != CMD_ENQUEUE) begin
                  post_in = ST_EMPTY;
               end else begin
                  unique case (cmd)
                     CMD_ENQUEUE: begin
                        if (occ_ff >= cap) begin
                           post_in = ST_OVERFLOW;
                        end else begin
                           ram_wr_en = 1'b1;
                           tail_in   = step_up(tail_ff, cap);
                           occ_in    = occ_ff + OCC_W'(1);
                           post_in   = ST_OK;
                        end
                     end
                     CMD_DEQUEUE: begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        occ_in      = occ_ff - OCC_W'(1);
                        if (occ_ff == OCC_W'(1)) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           head_in = head_up;
                        end
                        state_in = S_DEQ;
                     end
                     CMD_TRAVERSE: begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = tail_dn;
                        walk_in     = tail_dn;
                        remain_in   = occ_ff;
                        state_in    = S_TRAV;
                     end
                     CMD_SEARCH: begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = head_ff;
                        walk_in     = head_ff;
                        remain_in   = occ_ff;
                        key_in      = val_word;
                        state_in    = S_SCAN;
                     end
                     default: state_in = S_POST;
                  endcase
               end
            end
         end
         // Single-beat reply from staged status and count
         S_POST: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = post_ff;
               rsp_data_in   = '0;
               rsp_count_in  = CAP_W'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DEQ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = rd_word32;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         // One word per beat, newest first; next read overlaps the load
         S_TRAV: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = rd_word32;
               rsp_count_in  = '0;
               rsp_last_in   = (remain_ff == OCC_W'(1));
               if (remain_ff == OCC_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = walk_dn;
                  walk_in     = walk_dn;
                  remain_in   = remain_ff - OCC_W'(1);
               end
            end
         end
         // Compare one slot per cycle, oldest first
         S_SCAN: begin
            count_in = count_ff + OCC_W'(hit);
            if (remain_ff == OCC_W'(1)) begin
               post_in  = ST_OK;
               state_in = S_POST;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = walk_up;
               walk_in     = walk_up;
               remain_in   = remain_ff - OCC_W'(1);
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_ctl.idx_clear) begin
         head_in = '0;
         tail_in = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk and payload registers
   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      remain_ff     <= remain_in;
      count_ff      <= count_in;
      key_ff        <= key_in;
      post_ff       <= post_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_count_ff, rsp_data_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Occupancy stays within the live capacity
   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cap)
      else $error("occupancy above capacity");

   // An empty queue has both pointers rewound
   a_empty_rewind: assert property (@(posedge clock) disable iff (reset)
      occ_ff == '0 |-> head_ff == '0 && tail_ff == '0)
      else $error("empty queue with stray pointers");

   // A walk never runs with nothing left
   a_walk_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TRAV || state_ff == S_SCAN) |-> remain_ff != '0 && occ_ff != '0)
      else $error("walk with no remaining slots");

   // Error replies are single beats with no data
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_data_ff == '0 && rsp_last_ff
      && rsp_count_ff == '0)
      else $error("malformed error reply");

endmodule

>>> hdl/cqs_ram.sv
module cqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/cqs_csr.sv
module cqs_csr #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [cqs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   input  logic                           queue_empty,
   output cqs_pkg::csr_ctl_type           ctl
);
   import cqs_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] cap_in;
   logic             wr_hit;

   assign pready = 1'b1;

   // Capacity only moves while the queue is empty
   assign wr_hit = psel && penable && pwrite && pready
                   && (paddr[2] == REG_CAPACITY) && queue_empty;

   always_comb begin
      cap_in = cap_ff;
      if (wr_hit) begin
         cap_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Read back the raw register
   assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_ff) : 32'd0;

   // Clamp: zero acts as one, above the build depth acts as the depth
   always_comb begin
      if (cap_ff == '0) begin
         ctl.cap = CAP_W'(1);
      end else if (cap_ff > CAP_W'(DEPTH)) begin
         ctl.cap = CAP_W'(DEPTH);
      end else begin
         ctl.cap = cap_ff;
      end
      ctl.idx_clear = wr_hit;
   end

endmodule
